@@ hw/rtl/sfr_pkg.sv @@
// Shared types and constants for the starfield rotate/project block.
// Used by sfr_core and starfield_rotate_project; no dependencies.
package sfr_pkg;

    localparam int MAX_STARS = 64;

    localparam int SIN_A = 25736;
    localparam int SIN_B = 10583;
    localparam int SIN_C = 1231;

    typedef enum logic [0:0] {
        ACT_LOAD   = 1'b0,
        ACT_RENDER = 1'b1
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIN,
        ST_PROD1,
        ST_PROD2,
        ST_ROUND,
        ST_RUN,
        ST_DRAIN
    } state_t;

endpackage

@@ hw/rtl/sfr_core.sv @@
// Sine/cosine sequencer, rotation matrix build and per-star transform pipeline.
// Depends on sfr_pkg; star memory lives here, with a registered read port.
module sfr_core
    import sfr_pkg::*;
#(
    parameter int MAX_RADIUS = 255
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [6:0]           star_count,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_action,
    input  logic signed [15:0]   in_ux,
    input  logic signed [15:0]   in_uy,
    input  logic signed [15:0]   in_uz,
    input  logic [7:0]           in_rad,
    input  logic [15:0]          in_ax,
    input  logic [15:0]          in_ay,
    input  logic [15:0]          in_az,
    input  logic [11:0]          in_cx,
    input  logic [11:0]          in_cy,
    input  logic [11:0]          in_hw,
    input  logic [11:0]          in_hh,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [5:0]           out_index,
    output logic signed [15:0]   out_x,
    output logic signed [15:0]   out_y,
    output logic [8:0]           out_diam,
    output logic                 out_last
);

    localparam int AW = (MAX_STARS > 1) ? $clog2(MAX_STARS) : 1;
    localparam int CW = $clog2(MAX_STARS + 1);

    // Star memory: x, y, z, radius packed per entry
    logic [55:0] mem [MAX_STARS];
    logic [55:0] rd_data_reg;

    state_t state_reg, state_next;
    logic [AW-1:0] lp_reg, lp_next;
    logic [CW-1:0] n_eff;

    logic [15:0] ang_reg [3];
    logic [11:0] cx_reg, cy_reg, hw_reg, hh_reg;
    logic signed [15:0] sn_reg [3];
    logic signed [15:0] cs_reg [3];
    logic [2:0] sc_reg, sc_next;         // sine evaluation step 0..5
    logic [2:0] ph_reg, ph_next;         // polynomial phase within one sine
    logic [14:0] px_reg;                 // quarter-wave position
    logic [14:0] px2_reg;
    logic [31:0] pt_reg;
    logic        pneg_reg;

    // Matrix products: pairs then triples in Q42
    logic signed [31:0] p_reg [6];
    logic signed [47:0] t_reg [6];
    logic signed [17:0] m_reg [6];

    // Run pipeline
    logic [CW-1:0] rd_cnt_reg;           // stars issued to memory
    logic          v1_reg, v2_reg, v3_reg;
    logic [AW-1:0] i1_reg, i2_reg, i3_reg;
    logic          l1_reg, l2_reg, l3_reg;
    logic signed [33:0] pr_reg [6];
    logic [7:0]    r2_reg, r3_reg;
    logic signed [35:0] dx_reg, dy_reg;
    logic          ov_reg;
    logic [5:0]    oi_reg;
    logic signed [15:0] ox_reg, oy_reg;
    logic [8:0]    od_reg;
    logic          ol_reg;

    logic stall;
    logic issue;
    logic accept;

    always_comb
    begin
        if (star_count == 7'd0)
            n_eff = CW'(1);
        else if ({25'd0, star_count} > MAX_STARS)
            n_eff = CW'(MAX_STARS);
        else
            n_eff = CW'(star_count);
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign stall    = ov_reg && !out_ready;
    assign issue    = (state_reg == ST_RUN) && !stall && (rd_cnt_reg < n_eff);

    // Memory write and read
    logic [7:0] rad_sat;
    assign rad_sat = (in_rad > 8'(MAX_RADIUS)) ? 8'(MAX_RADIUS) : in_rad;

    always_ff @(posedge clk)
    begin
        if (accept && in_action == ACT_LOAD)
            mem[lp_reg] <= {rad_sat, in_uz, in_uy, in_ux};
        if (!stall)
            rd_data_reg <= mem[rd_cnt_reg[AW-1:0]];
    end

    // Load pointer
    always_comb
    begin
        lp_next = lp_reg;
        if (accept)
        begin
            if (in_action == ACT_RENDER)
                lp_next = '0;
            else if ({1'b0, lp_reg} + (AW+1)'(1) >= (AW+1)'(n_eff))
                lp_next = '0;
            else
                lp_next = lp_reg + AW'(1);
        end
    end

    // Sine stage helpers: angle selection, quadrant fold
    logic [15:0] a_sel;
    logic [1:0]  sidx;
    assign sidx  = (sc_reg >= 3'd3) ? 2'(sc_reg - 3'd3) : 2'(sc_reg);
    assign a_sel = (sc_reg >= 3'd3) ? ang_reg[sidx] + 16'd16384 : ang_reg[sidx];

    logic [31:0] mul_a, mul_b, mul_p;
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (ph_reg)
            3'd1:    begin mul_a = {17'd0, px_reg}; mul_b = {17'd0, px_reg}; end
            3'd2:    begin mul_a = 32'(SIN_C); mul_b = {17'd0, px2_reg}; end
            3'd3:    begin mul_a = 32'(SIN_B) - pt_reg; mul_b = {17'd0, px2_reg}; end
            3'd4:    begin mul_a = {17'd0, px_reg}; mul_b = 32'(SIN_A) - pt_reg; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        mul_p = mul_a * mul_b;
    end

    state_t st_n;
    always_comb
    begin
        st_n       = state_reg;
        sc_next    = sc_reg;
        ph_next    = ph_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept && in_action == ACT_RENDER)
                begin
                    st_n = ST_SIN;
                    sc_next = '0;
                    ph_next = '0;
                end
            ST_SIN:
                if (ph_reg == 3'd5)
                begin
                    ph_next = '0;
                    if (sc_reg == 3'd5)
                        st_n = ST_PROD1;
                    else
                        sc_next = sc_reg + 3'd1;
                end
                else
                    ph_next = ph_reg + 3'd1;
            ST_PROD1: st_n = ST_PROD2;
            ST_PROD2: st_n = ST_ROUND;
            ST_ROUND: st_n = ST_RUN;
            ST_RUN:
                if (rd_cnt_reg >= n_eff && !issue)
                    st_n = ST_DRAIN;
            ST_DRAIN:
                if (!v1_reg && !v2_reg && !v3_reg && !ov_reg)
                    st_n = ST_IDLE;
            default: st_n = ST_IDLE;
        endcase
        state_next = st_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lp_reg    <= '0;
            sc_reg    <= '0;
            ph_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lp_reg    <= lp_next;
            sc_reg    <= sc_next;
            ph_reg    <= ph_next;
        end
    end

    // Sine datapath: phase 0 folds quadrant, 1..4 polynomial, 5 stores result
    always_ff @(posedge clk)
    begin
        if (accept && in_action == ACT_RENDER)
        begin
            ang_reg[0] <= in_ax;
            ang_reg[1] <= in_ay;
            ang_reg[2] <= in_az;
            cx_reg <= in_cx;
            cy_reg <= in_cy;
            hw_reg <= in_hw;
            hh_reg <= in_hh;
        end
        if (state_reg == ST_SIN)
        begin
            unique case (ph_reg)
                3'd0:
                begin
                    px_reg   <= a_sel[14] ? 15'd16384 - {1'b0, a_sel[13:0]}
                                          : {1'b0, a_sel[13:0]};
                    pneg_reg <= a_sel[15];
                end
                3'd1: px2_reg <= 15'(mul_p >> 14);
                3'd2: pt_reg  <= mul_p >> 14;
                3'd3: pt_reg  <= mul_p >> 14;
                3'd4: pt_reg  <= mul_p >> 14;
                3'd5:
                begin
                    if (sc_reg >= 3'd3)
                        cs_reg[sidx] <= pneg_reg ? -$signed(16'(pt_reg))
                                                 : $signed(16'(pt_reg));
                    else
                        sn_reg[sidx] <= pneg_reg ? -$signed(16'(pt_reg))
                                                 : $signed(16'(pt_reg));
                end
                default: ;
            endcase
        end
        // Pair products (Q28)
        if (state_reg == ST_PROD1)
        begin
            p_reg[0] <= cs_reg[1] * cs_reg[2];
            p_reg[1] <= sn_reg[0] * sn_reg[1];
            p_reg[2] <= sn_reg[1] * cs_reg[2];
            p_reg[3] <= sn_reg[2] * sn_reg[0];
            p_reg[4] <= cs_reg[1] * sn_reg[2];
            p_reg[5] <= sn_reg[0] * cs_reg[1];
        end
        // Combine to Q42
        if (state_reg == ST_PROD2)
        begin
            t_reg[0] <= 48'(p_reg[0]) * 48'sd16384 - 48'(p_reg[1]) * 48'(sn_reg[2]);
            t_reg[1] <= -(48'(cs_reg[0]) * 48'(sn_reg[2]) * 48'sd16384);
            t_reg[2] <= 48'(p_reg[2]) * 48'sd16384 + 48'(p_reg[3]) * 48'(cs_reg[1]);
            t_reg[3] <= 48'(p_reg[4]) * 48'sd16384 + 48'(p_reg[1]) * 48'(cs_reg[2]);
            t_reg[4] <= 48'(cs_reg[0]) * 48'(cs_reg[2]) * 48'sd16384;
            t_reg[5] <= 48'(sn_reg[1]) * 48'(sn_reg[2]) * 48'sd16384
                      - 48'(p_reg[5]) * 48'(cs_reg[2]);
        end
        if (state_reg == ST_ROUND)
        begin
            for (int k = 0; k < 6; k++)
                m_reg[k] <= 18'((t_reg[k] + 48'sd134217728) >>> 28);
        end
    end

    // Star pipeline: issue -> memory read -> products -> sums -> project
    logic signed [15:0] ux, uy, uz;
    assign ux = rd_data_reg[15:0];
    assign uy = rd_data_reg[31:16];
    assign uz = rd_data_reg[47:32];

    function automatic logic signed [15:0] proj(input logic signed [35:0] d,
                                                 input logic [11:0] half,
                                                 input logic [11:0] cen,
                                                 input logic [7:0] sz);
        logic signed [49:0] v;
        logic signed [21:0] p;
        logic [49:0] mag;
        v = 50'(d) * $signed({1'b0, half}) + $signed({8'd0, cen, 28'd0} );
        mag = v[49] ? 50'(-v) : v;
        p = v[49] ? -$signed(22'(mag >> 28)) : $signed(22'(mag >> 28));
        p = p - $signed({14'd0, sz});
        if (p > 22'sd32767)
            return 16'sd32767;
        else if (p < -22'sd32768)
            return -16'sd32768;
        else
            return 16'(p);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_cnt_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_ROUND)
                rd_cnt_reg <= '0;
            else if (issue)
                rd_cnt_reg <= rd_cnt_reg + CW'(1);
            if (!stall)
            begin
                v1_reg <= issue;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                ov_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            i1_reg <= rd_cnt_reg[AW-1:0];
            l1_reg <= (rd_cnt_reg + CW'(1) == n_eff);
            i2_reg <= i1_reg;
            l2_reg <= l1_reg;
            r2_reg <= rd_data_reg[55:48];
            pr_reg[0] <= m_reg[0] * ux;
            pr_reg[1] <= m_reg[1] * uy;
            pr_reg[2] <= m_reg[2] * uz;
            pr_reg[3] <= m_reg[3] * ux;
            pr_reg[4] <= m_reg[4] * uy;
            pr_reg[5] <= m_reg[5] * uz;
            i3_reg <= i2_reg;
            l3_reg <= l2_reg;
            r3_reg <= r2_reg;
            dx_reg <= 36'(pr_reg[0]) + 36'(pr_reg[1]) + 36'(pr_reg[2]);
            dy_reg <= 36'(pr_reg[3]) + 36'(pr_reg[4]) + 36'(pr_reg[5]);
            oi_reg <= 6'(i3_reg);
            ol_reg <= l3_reg;
            od_reg <= 9'd2 + {1'b0, r3_reg};
            ox_reg <= proj(dx_reg, hw_reg, cx_reg, r3_reg);
            oy_reg <= proj(dy_reg, hh_reg, cy_reg, r3_reg);
        end
    end

    assign out_valid = ov_reg;
    assign out_index = oi_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_diam  = od_reg;
    assign out_last  = ol_reg;

endmodule

@@ hw/rtl/starfield_rotate_project.sv @@
// Top level of the starfield rotate/project block: stream ports and packing.
// Depends on sfr_pkg and sfr_core.
//
// A load transaction stores one star. A render transaction first runs six
// sequential sine evaluations on one shared multiplier and the matrix build, then
// reads one star per cycle through the star memory read port unless the output
// stalls, and drains the pipeline. The next transaction is taken once the last
// disk has been delivered.
module starfield_rotate_project
    import sfr_pkg::*;
#(
    parameter int MAX_RADIUS = 255
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [6:0]   cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // unit_x, unit_y, unit_z, star_radius, angle_x, angle_y, angle_z,
    // center_x, center_y, half_width, half_height (from bit 0)
    input  logic [151:0] s_tdata,
    input  logic         s_tuser,     // action
    output logic         m_tvalid,
    input  logic         m_tready,
    // star_index, screen_x, screen_y, diameter (from bit 0), zero pad
    output logic [47:0]  m_tdata,
    output logic         m_tlast
);

    logic [6:0] star_count_reg;
    logic [5:0] idx;
    logic signed [15:0] sx, sy;
    logic [8:0] diam;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            star_count_reg <= 7'd1;
        else if (cfg_we)
            star_count_reg <= cfg_wdata;
    end

    sfr_core #(
        .MAX_RADIUS(MAX_RADIUS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .star_count(star_count_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_ux     (s_tdata[15:0]),
        .in_uy     (s_tdata[31:16]),
        .in_uz     (s_tdata[47:32]),
        .in_rad    (s_tdata[55:48]),
        .in_ax     (s_tdata[71:56]),
        .in_ay     (s_tdata[87:72]),
        .in_az     (s_tdata[103:88]),
        .in_cx     (s_tdata[115:104]),
        .in_cy     (s_tdata[127:116]),
        .in_hw     (s_tdata[139:128]),
        .in_hh     (s_tdata[151:140]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (idx),
        .out_x     (sx),
        .out_y     (sy),
        .out_diam  (diam),
        .out_last  (m_tlast)
    );

    assign m_tdata = {1'b0, diam, sy, sx, idx};

endmodule

@@ dv/starfield_rotate_project_chk.sv @@
// Checker for starfield_rotate_project: watches the config port and both streams,
// predicts every disk of a render frame and compares each transaction field by field.
// Depends on sfr_pkg.
`timescale 1ns / 100ps

module starfield_rotate_project_chk
    import sfr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [6:0]   cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [151:0] s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [47:0]  m_tdata,
    input  logic         m_tlast,
    output int           fails,
    output int           pending
);

    typedef struct {
        logic [5:0]  index;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [8:0]  diam;
        logic        last;
    } disk_t;

    logic signed [15:0] vec_x [MAX_STARS];
    logic signed [15:0] vec_y [MAX_STARS];
    logic signed [15:0] vec_z [MAX_STARS];
    logic [7:0]         size_mem [MAX_STARS];
    int unsigned        slot_ptr;
    logic [6:0]         count_reg;
    disk_t              disks_due [$];

    assign pending = disks_due.size();

    function automatic int unsigned stars_active();
        if (count_reg < 1) return 1;
        if (count_reg > MAX_STARS) return MAX_STARS;
        return count_reg;
    endfunction

    function automatic longint sine_q14(input logic [15:0] ang);
        int unsigned x, x2, t;
        longint s;
        x = ang[14] ? 16384 - ang[13:0] : ang[13:0];
        x2 = (x * x) >> 14;
        t = (SIN_C * x2) >> 14;
        t = SIN_B - t;
        t = (t * x2) >> 14;
        t = SIN_A - t;
        s = (x * t) >> 14;
        return ang[15] ? -s : s;
    endfunction

    function automatic longint cosine_q14(input logic [15:0] ang);
        logic [15:0] shifted;
        shifted = ang + 16'h4000;
        return sine_q14(shifted);
    endfunction

    // Q42 -> Q14, add half then floor
    function automatic longint round_q28(input longint v);
        return (v + (64'sd1 <<< 27)) >>> 28;
    endfunction

    function automatic logic [15:0] to_screen(input longint d, input longint half,
                                              input longint centre, input longint size);
        longint v, p;
        v = d * half + (centre <<< 28);
        p = (v < 0) ? -((-v) >>> 28) : (v >>> 28);
        p = p - size;
        if (p > 32767) p = 32767;
        if (p < -32768) p = -32768;
        return p[15:0];
    endfunction

    task automatic predict_frame(input logic [151:0] d);
        longint cx, sx, cy, sy, cz, sz;
        longint m00, m01, m02, m10, m11, m12, dx, dy, ux, uy, uz;
        int unsigned n;
        disk_t e;
        n = stars_active();
        cx = cosine_q14(d[71:56]);  sx = sine_q14(d[71:56]);
        cy = cosine_q14(d[87:72]);  sy = sine_q14(d[87:72]);
        cz = cosine_q14(d[103:88]); sz = sine_q14(d[103:88]);
        m00 = round_q28(cy * cz * 16384 - sx * sy * sz);
        m01 = round_q28(-cx * sz * 16384);
        m02 = round_q28(sy * cz * 16384 + sz * sx * cy);
        m10 = round_q28(cy * sz * 16384 + sx * sy * cz);
        m11 = round_q28(cx * cz * 16384);
        m12 = round_q28(sy * sz * 16384 - sx * cy * cz);
        for (int i = 0; i < n; i++)
        begin
            ux = vec_x[i];
            uy = vec_y[i];
            uz = vec_z[i];
            dx = m00 * ux + m01 * uy + m02 * uz;
            dy = m10 * ux + m11 * uy + m12 * uz;
            e.index = i[5:0];
            e.sx = to_screen(dx, d[139:128], d[115:104], size_mem[i]);
            e.sy = to_screen(dy, d[151:140], d[127:116], size_mem[i]);
            e.diam = 9'd2 + size_mem[i];
            e.last = (i + 1 == n);
            disks_due.push_back(e);
        end
        slot_ptr = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        disk_t e;
        if (!rst_n)
        begin
            slot_ptr  <= 0;
            count_reg <= 7'd1;
            fails     <= 0;
            disks_due.delete();
        end
        else
        begin
            if (cfg_we)
                count_reg = cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                if (action_t'(s_tuser) == ACT_LOAD)
                begin
                    if (slot_ptr >= MAX_STARS) slot_ptr = 0;
                    vec_x[slot_ptr]    = s_tdata[15:0];
                    vec_y[slot_ptr]    = s_tdata[31:16];
                    vec_z[slot_ptr]    = s_tdata[47:32];
                    size_mem[slot_ptr] = s_tdata[55:48];
                    slot_ptr = (slot_ptr + 1 >= stars_active()) ? 0 : slot_ptr + 1;
                end
                else
                    predict_frame(s_tdata);
            end
            if (m_tvalid && m_tready)
            begin
                if (disks_due.size() == 0)
                begin
                    $error("unexpected disk transaction: tdata=%h", m_tdata);
                    fails++;
                end
                else
                begin
                    e = disks_due.pop_front();
                    if (m_tdata[5:0] !== e.index)
                    begin
                        $error("star_index: expected %0d, got %0d", e.index, m_tdata[5:0]);
                        fails++;
                    end
                    if (m_tdata[21:6] !== e.sx)
                    begin
                        $error("screen_x: expected %0d, got %0d",
                               $signed(e.sx), $signed(m_tdata[21:6]));
                        fails++;
                    end
                    if (m_tdata[37:22] !== e.sy)
                    begin
                        $error("screen_y: expected %0d, got %0d",
                               $signed(e.sy), $signed(m_tdata[37:22]));
                        fails++;
                    end
                    if (m_tdata[46:38] !== e.diam)
                    begin
                        $error("diameter: expected %0d, got %0d", e.diam, m_tdata[46:38]);
                        fails++;
                    end
                    if (m_tlast !== e.last)
                    begin
                        $error("last_star: expected %0d, got %0d", e.last, m_tlast);
                        fails++;
                    end
                end
            end
        end
    end

endmodule

@@ dv/starfield_rotate_project_tb.sv @@
// Testbench top for starfield_rotate_project: clock, reset, star loads and renders.
// Depends on sfr_pkg, the block and starfield_rotate_project_chk.
`timescale 1ns / 100ps

module starfield_rotate_project_tb
    import sfr_pkg::*;
();

    localparam int CYCLE_LIMIT = 1000000;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [6:0]   cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [151:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;
    logic         m_tlast;
    int           fails;
    int           pending;
    int           cycles;
    int           send_idle_pct;
    int           recv_stall_pct;

    // mirror of the slot pointer and of slots written since reset
    int unsigned  next_slot;
    logic [63:0]  written;
    logic [6:0]   count_val;

    starfield_rotate_project DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    starfield_rotate_project_chk u_chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fails(fails), .pending(pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("starfield_rotate_project_tb: FAIL");
            $finish;
        end
    end

    function automatic int unsigned stars_active();
        if (count_val < 1) return 1;
        if (count_val > MAX_STARS) return MAX_STARS;
        return count_val;
    endfunction

    function automatic logic [15:0] pick_unit();
        if ($urandom_range(9) == 0) return 16'($urandom());
        return 16'($urandom_range(32768) - 16384);
    endfunction

    task automatic send_item(input logic [151:0] d, input action_t act);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= d;
        s_tuser  <= act;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (act == ACT_LOAD)
        begin
            if (next_slot >= 64) next_slot = 0;
            written[next_slot] = 1'b1;
            next_slot = (next_slot + 1 >= stars_active()) ? 0 : next_slot + 1;
        end
        else
            next_slot = 0;
    endtask

    task automatic load_star(input logic [15:0] ux, input logic [15:0] uy,
                             input logic [15:0] uz, input logic [7:0] sz);
        logic [151:0] d;
        d = 152'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
        d[55:0] = {sz, uz, uy, ux};
        send_item(d, ACT_LOAD);
    endtask

    task automatic load_random_star();
        load_star(pick_unit(), pick_unit(), pick_unit(), 8'($urandom()));
    endtask

    // load slots until every active slot holds a star, then render
    task automatic render(input logic [15:0] ax, input logic [15:0] ay, input logic [15:0] az,
                          input logic [11:0] cx, input logic [11:0] cy,
                          input logic [11:0] hw, input logic [11:0] hh);
        logic [151:0] d;
        while ((written & ((64'd1 << stars_active()) - 1) |
                (stars_active() == 64 ? 64'd0 : ~((64'd1 << stars_active()) - 1)))
               != {64{1'b1}})
            load_random_star();
        d = 152'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
        d[151:56] = {hh, hw, cy, cx, az, ay, ax};
        send_item(d, ACT_RENDER);
    endtask

    task automatic render_random();
        render(16'($urandom()), 16'($urandom()), 16'($urandom()), 12'($urandom()),
               12'($urandom()), 12'($urandom()), 12'($urandom()));
    endtask

    task automatic drain_all();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_count(input logic [6:0] v);
        drain_all();
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        count_val = v;
    endtask

    task automatic random_phase(input int items, input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < items; i++)
        begin
            if ($urandom_range(4) == 0)
                render_random();
            else
                load_random_star();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cycles = 0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        next_slot = 0;
        written = '0;
        count_val = 7'd1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme vectors, sizes, angles and screen parameters
        write_count(7'd4);
        load_star(16'sd16384, -16'sd16384, 16'h8000, 8'd0);
        load_star(-16'sd16384, 16'sd16384, 16'h7FFF, 8'd255);
        load_star(16'h7FFF, 16'h8000, 16'd0, 8'd1);
        load_star(16'd0, 16'd0, 16'sd16384, 8'd128);
        render(16'd0, 16'd0, 16'd0, 12'd2048, 12'd2048, 12'd1000, 12'd1000);
        render(16'h4000, 16'hC000, 16'h8000, 12'd0, 12'd0, 12'd4095, 12'd4095);
        render(16'h7FFF, 16'h8000, 16'h4000, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
        render(16'h2000, 16'h6000, 16'hA000, 12'd4095, 12'd0, 12'd0, 12'd0);
        render(16'hFFFF, 16'h0001, 16'hE000, 12'd100, 12'd3000, 12'd4095, 12'd1);
        // out of range counts: zero acts as one, large acts as the table size
        write_count(7'd0);
        load_star(16'sd16384, 16'sd0, 16'sd0, 8'd7);
        render(16'h1234, 16'h5678, 16'h9ABC, 12'd500, 12'd600, 12'd300, 12'd200);
        write_count(7'd127);
        render(16'h0800, 16'h1000, 16'h1800, 12'd2048, 12'd2048, 12'd2000, 12'd2000);

        write_count(7'd64);
        random_phase(100, 0, 0);
        write_count(7'($urandom_range(64, 1)));
        random_phase(50, 54, 0);
        // hold the sender until every disk has come out
        drain_all();
        random_phase(50, 54, 0);
        write_count(7'($urandom_range(8, 1)));
        random_phase(100, 0, 54);
        write_count(7'd1);
        random_phase(40, 6, 6);
        write_count(7'($urandom_range(64, 1)));
        random_phase(80, 6, 6);

        drain_all();
        if (fails == 0)
            $display("starfield_rotate_project_tb: PASS");
        else
            $display("starfield_rotate_project_tb: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_core.sv
hw/rtl/starfield_rotate_project.sv
dv/starfield_rotate_project_chk.sv
dv/starfield_rotate_project_tb.sv
